FILE: src/pglsp_pkg.sv
`default_nettype none
package pglsp_pkg;

  // Group length and plane counter
  localparam int GROUP_MAX = 64;
  localparam int CNT_W     = $clog2(GROUP_MAX + 1);

  // Field widths
  localparam int NRM_W = 16;
  localparam int OFS_W = 32;
  localparam int PT_W  = 32;

  // Accumulator and solver widths
  localparam int MAT_W = 40;              // normal matrix sums, Q10.30
  localparam int VEC_W = 54;              // weighted offset sums, Q23.31
  localparam int COF_W = 81;              // adjugate entries
  localparam int DET_W = 122;             // determinant
  localparam int NUM_W = 136;             // adjugate times vector
  localparam int OPA_W = COF_W;           // wide multiplier operand
  localparam int OPB_W = 64;              // digit operand, sign extended
  localparam int DIG_W = 16;              // one digit of the B operand
  localparam int PP_W  = OPA_W + DIG_W + 1;
  localparam int MAT_SUM_W = MAT_W + 2;
  localparam int VEC_SUM_W = VEC_W + 2;

  // Divider: quotient bits 32..0 plus one range check step
  localparam int RND_SHIFT = 16;
  localparam int DIV_STEPS = PT_W + 2;
  localparam int DSTEP_W   = $clog2(DIV_STEPS + 1);
  localparam int QB_W      = PT_W + 1;
  localparam int DIV_W     = DET_W + DIV_STEPS - 1;

  localparam logic signed [MAT_W-1:0] MAT_MAX = {1'b0, {(MAT_W-1){1'b1}}};
  localparam logic signed [MAT_W-1:0] MAT_MIN = {1'b1, {(MAT_W-1){1'b0}}};
  localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
  localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};
  localparam logic signed [PT_W-1:0]  PT_MAX  = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic signed [PT_W-1:0]  PT_MIN  = {1'b1, {(PT_W-1){1'b0}}};

  // Term program
  localparam int TERM_W = 6;
  localparam logic [TERM_W-1:0] TERM_ACC_LAST = 6'd8;
  localparam logic [TERM_W-1:0] TERM_SOLVE0   = 6'd9;
  localparam logic [TERM_W-1:0] TERM_NUM0     = 6'd24;

  localparam logic [1:0] NDIG_U = 2'd0;   // normal component: one digit
  localparam logic [1:0] NDIG_M = 2'd2;   // matrix sum: three digits
  localparam logic [1:0] NDIG_V = 2'd3;   // offset sum: four digits

  localparam logic [1:0] LAST_COORD = 2'd2;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic signed [OFS_W-1:0] offset;
    logic                    last_plane;
  } plane_t;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    logic                   singular;
    logic                   clipped;
  } point_t;

  typedef enum logic [4:0] {
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
    OP_V0, OP_V1, OP_V2,
    OP_C0, OP_C1, OP_C2, OP_C3, OP_C4, OP_C5,
    OP_U0, OP_U1, OP_U2, OP_H
  } opnd_t;

  typedef enum logic [4:0] {
    DST_NONE,
    DST_M0, DST_M1, DST_M2, DST_M3, DST_M4, DST_M5,
    DST_V0, DST_V1, DST_V2,
    DST_C0, DST_C1, DST_C2, DST_C3, DST_C4, DST_C5,
    DST_DET, DST_NUM
  } dest_t;

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_SOLVE, S_DRAIN, S_NEXT, S_DIV, S_EMIT
  } state_t;

  typedef struct packed {
    opnd_t      a_sel;
    opnd_t      b_sel;
    logic [1:0] ndig;
    logic       sub;
    logic       first;
    dest_t      dest;
  } term_t;

  typedef struct packed {
    logic       load;
    logic       issue;
    opnd_t      a_sel;
    opnd_t      b_sel;
    logic [1:0] digit;
    logic       top;
    logic       sub;
    logic       first;
    dest_t      dest;
    logic       div_start;
    logic [1:0] coord;
    logic       set_sing;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic group_full;
    logic last;
    logic in_last;
    logic det_zero;
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic term_t mk(opnd_t a, opnd_t b, logic [1:0] n, logic s, logic f,
                               dest_t d);
    term_t t;
    t.a_sel = a;
    t.b_sel = b;
    t.ndig  = n;
    t.sub   = s;
    t.first = f;
    t.dest  = d;
    return t;
  endfunction

  // Sequence of products: plane accumulation, adjugate, determinant, numerators
  function automatic term_t term_rom(logic [TERM_W-1:0] idx);
    term_t t;
    case (idx)
      6'd0:  t = mk(OP_U0, OP_U0, NDIG_U, 1'b0, 1'b0, DST_M0);
      6'd1:  t = mk(OP_U1, OP_U0, NDIG_U, 1'b0, 1'b0, DST_M1);
      6'd2:  t = mk(OP_U2, OP_U0, NDIG_U, 1'b0, 1'b0, DST_M2);
      6'd3:  t = mk(OP_H,  OP_U0, NDIG_U, 1'b0, 1'b0, DST_V0);
      6'd4:  t = mk(OP_U1, OP_U1, NDIG_U, 1'b0, 1'b0, DST_M3);
      6'd5:  t = mk(OP_U2, OP_U1, NDIG_U, 1'b0, 1'b0, DST_M4);
      6'd6:  t = mk(OP_H,  OP_U1, NDIG_U, 1'b0, 1'b0, DST_V1);
      6'd7:  t = mk(OP_U2, OP_U2, NDIG_U, 1'b0, 1'b0, DST_M5);
      6'd8:  t = mk(OP_H,  OP_U2, NDIG_U, 1'b0, 1'b0, DST_V2);
      6'd9:  t = mk(OP_M3, OP_M5, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd10: t = mk(OP_M4, OP_M4, NDIG_M, 1'b1, 1'b0, DST_C0);
      6'd11: t = mk(OP_M2, OP_M4, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd12: t = mk(OP_M1, OP_M5, NDIG_M, 1'b1, 1'b0, DST_C1);
      6'd13: t = mk(OP_M1, OP_M4, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd14: t = mk(OP_M2, OP_M3, NDIG_M, 1'b1, 1'b0, DST_C2);
      6'd15: t = mk(OP_M0, OP_M5, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd16: t = mk(OP_M2, OP_M2, NDIG_M, 1'b1, 1'b0, DST_C3);
      6'd17: t = mk(OP_M1, OP_M2, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd18: t = mk(OP_M0, OP_M4, NDIG_M, 1'b1, 1'b0, DST_C4);
      6'd19: t = mk(OP_M0, OP_M3, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd20: t = mk(OP_M1, OP_M1, NDIG_M, 1'b1, 1'b0, DST_C5);
      6'd21: t = mk(OP_C0, OP_M0, NDIG_M, 1'b0, 1'b1, DST_NONE);
      6'd22: t = mk(OP_C1, OP_M1, NDIG_M, 1'b0, 1'b0, DST_NONE);
      6'd23: t = mk(OP_C2, OP_M2, NDIG_M, 1'b0, 1'b0, DST_DET);
      6'd24: t = mk(OP_C0, OP_V0, NDIG_V, 1'b0, 1'b1, DST_NONE);
      6'd25: t = mk(OP_C1, OP_V1, NDIG_V, 1'b0, 1'b0, DST_NONE);
      6'd26: t = mk(OP_C2, OP_V2, NDIG_V, 1'b0, 1'b0, DST_NUM);
      6'd27: t = mk(OP_C1, OP_V0, NDIG_V, 1'b0, 1'b1, DST_NONE);
      6'd28: t = mk(OP_C3, OP_V1, NDIG_V, 1'b0, 1'b0, DST_NONE);
      6'd29: t = mk(OP_C4, OP_V2, NDIG_V, 1'b0, 1'b0, DST_NUM);
      6'd30: t = mk(OP_C2, OP_V0, NDIG_V, 1'b0, 1'b1, DST_NONE);
      6'd31: t = mk(OP_C4, OP_V1, NDIG_V, 1'b0, 1'b0, DST_NONE);
      6'd32: t = mk(OP_C5, OP_V2, NDIG_V, 1'b0, 1'b0, DST_NUM);
      default: t = mk(OP_U0, OP_U0, NDIG_U, 1'b0, 1'b0, DST_NONE);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: src/pglsp_div.sv
`default_nettype none
module pglsp_div import pglsp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic signed [DET_W-1:0] den,
  output logic                         done,
  output logic signed [PT_W-1:0]       res,
  output logic                         res_clip
);

  logic               busy;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   dsh;
  logic [QB_W-1:0]    q;
  logic [DSTEP_W-1:0] cnt;
  logic               neg;
  logic               big;

  logic [NUM_W-1:0]   an_mag;
  logic [DET_W-1:0]   ad_mag;
  logic               ge;
  logic [PT_W-1:0]    mag;
  logic               big_all;

  // Magnitudes and the compare of the restoring step
  always_comb begin
    an_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    ad_mag = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
    ge     = (rem >= dsh);
  end

  // Quotient of (|n|*2^16 + |d|) / (2|d|), first step only checks range
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy &&
              ((cnt == DSTEP_W'(DIV_STEPS)) ? ge : (cnt == DSTEP_W'(1)));
      if (start) begin
        busy <= 1'b1;
        rem  <= DIV_W'({an_mag, {RND_SHIFT{1'b0}}}) + DIV_W'(ad_mag);
        dsh  <= DIV_W'(ad_mag) << DIV_STEPS;
        q    <= '0;
        cnt  <= DSTEP_W'(DIV_STEPS);
        neg  <= num[NUM_W-1] ^ den[DET_W-1];
        big  <= 1'b0;
      end else if (busy) begin
        dsh <= dsh >> 1;
        cnt <= cnt - DSTEP_W'(1);
        if (cnt == DSTEP_W'(DIV_STEPS)) begin
          big <= ge;
          if (ge) begin
            busy <= 1'b0;
          end
        end else begin
          if (ge) begin
            rem <= rem - dsh;
          end
          q <= {q[QB_W-2:0], ge};
          if (cnt == DSTEP_W'(1)) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  // Sign and saturation
  always_comb begin
    mag     = q[PT_W-1:0];
    big_all = big | q[QB_W-1];
    if (neg) begin
      res_clip = big_all || (mag > {1'b1, {(PT_W-1){1'b0}}});
      res      = res_clip ? PT_MIN : PT_W'(-$signed(mag));
    end else begin
      res_clip = big_all || mag[PT_W-1];
      res      = res_clip ? PT_MAX : $signed(mag);
    end
  end

`ifndef ASSERT_OFF
  a_start_loads: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && (cnt == DSTEP_W'(DIV_STEPS)))
    else $error("divider did not load on start");
  a_big_first: assert property (@(posedge clk) disable iff (rst)
    busy && (cnt != DSTEP_W'(DIV_STEPS)) |-> !big)
    else $error("range overflow seen after the first step");
`endif

endmodule
`default_nettype wire

FILE: src/pglsp_dp.sv
`default_nettype none
module pglsp_dp import pglsp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire plane_t plane,
  input  wire cmd_t   cmd,
  output stat_t       stat,
  output point_t      point,
  output logic        point_valid,
  input  wire logic   point_ready
);

  // Latched plane
  logic signed [NRM_W-1:0] u0, u1, u2;
  logic signed [OFS_W-1:0] h;
  logic                    last;

  // Group state
  logic signed [MAT_W-1:0] mxx, mxy, mxz, myy, myz, mzz;
  logic signed [VEC_W-1:0] vx, vy, vz;
  logic [CNT_W-1:0]        planes;
  logic                    ovf;

  // Solver registers
  logic signed [COF_W-1:0] c00, c01, c02, c11, c12, c22;
  logic signed [DET_W-1:0] det;
  logic signed [NUM_W-1:0] num;
  logic signed [NUM_W-1:0] acc;
  logic signed [PT_W-1:0]  p0, p1, p2;
  logic                    cclip;
  logic                    sing;

  // Product stage
  logic signed [PP_W-1:0]  pp;
  logic [1:0]              pp_dig;
  logic                    pp_sub;
  logic                    pp_first;
  dest_t                   pp_dest;
  logic                    pp_valid;

  logic signed [OPA_W-1:0] a_opnd;
  logic signed [OPB_W-1:0] b_opnd;
  logic [DIG_W-1:0]        dsl;
  logic signed [DIG_W:0]   dig;

  logic                        pp_is_mat, pp_is_vec;
  logic signed [MAT_W-1:0]     mat_old, mat_new;
  logic signed [VEC_W-1:0]     vec_old, vec_new;
  logic signed [MAT_SUM_W-1:0] mat_sum;
  logic signed [VEC_SUM_W-1:0] vec_sum;
  logic                        mat_sat, vec_sat;
  logic signed [NUM_W-1:0]     pp_sh, acc_base, acc_sum;

  logic                    group_full;
  logic                    div_done;
  logic signed [PT_W-1:0]  div_res;
  logic                    div_clip;

  // Operand selection
  always_comb begin
    case (cmd.a_sel)
      OP_M0:   a_opnd = OPA_W'(mxx);
      OP_M1:   a_opnd = OPA_W'(mxy);
      OP_M2:   a_opnd = OPA_W'(mxz);
      OP_M3:   a_opnd = OPA_W'(myy);
      OP_M4:   a_opnd = OPA_W'(myz);
      OP_M5:   a_opnd = OPA_W'(mzz);
      OP_C0:   a_opnd = c00;
      OP_C1:   a_opnd = c01;
      OP_C2:   a_opnd = c02;
      OP_C3:   a_opnd = c11;
      OP_C4:   a_opnd = c12;
      OP_C5:   a_opnd = c22;
      OP_U0:   a_opnd = OPA_W'(u0);
      OP_U1:   a_opnd = OPA_W'(u1);
      OP_U2:   a_opnd = OPA_W'(u2);
      OP_H:    a_opnd = OPA_W'(h);
      default: a_opnd = '0;
    endcase
    case (cmd.b_sel)
      OP_M0:   b_opnd = OPB_W'(mxx);
      OP_M1:   b_opnd = OPB_W'(mxy);
      OP_M2:   b_opnd = OPB_W'(mxz);
      OP_M3:   b_opnd = OPB_W'(myy);
      OP_M4:   b_opnd = OPB_W'(myz);
      OP_M5:   b_opnd = OPB_W'(mzz);
      OP_V0:   b_opnd = OPB_W'(vx);
      OP_V1:   b_opnd = OPB_W'(vy);
      OP_V2:   b_opnd = OPB_W'(vz);
      OP_U0:   b_opnd = OPB_W'(u0);
      OP_U1:   b_opnd = OPB_W'(u1);
      OP_U2:   b_opnd = OPB_W'(u2);
      default: b_opnd = '0;
    endcase
    dsl = b_opnd[{cmd.digit, 4'b0000} +: DIG_W];
    dig = $signed({cmd.top & dsl[DIG_W-1], dsl});
  end

  // Multiplier stage: wide operand times one 16-bit digit
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= cmd.issue;
    end
    pp       <= PP_W'(a_opnd) * PP_W'(dig);
    pp_dig   <= cmd.digit;
    pp_sub   <= cmd.sub;
    pp_first <= cmd.first;
    pp_dest  <= cmd.issue ? cmd.dest : DST_NONE;
  end

  // Saturating accumulate of one plane product
  always_comb begin
    pp_is_mat = pp_dest inside {DST_M0, DST_M1, DST_M2, DST_M3, DST_M4, DST_M5};
    pp_is_vec = pp_dest inside {DST_V0, DST_V1, DST_V2};
    case (pp_dest)
      DST_M0:  mat_old = mxx;
      DST_M1:  mat_old = mxy;
      DST_M2:  mat_old = mxz;
      DST_M3:  mat_old = myy;
      DST_M4:  mat_old = myz;
      DST_M5:  mat_old = mzz;
      default: mat_old = '0;
    endcase
    case (pp_dest)
      DST_V0:  vec_old = vx;
      DST_V1:  vec_old = vy;
      DST_V2:  vec_old = vz;
      default: vec_old = '0;
    endcase
    mat_sum = MAT_SUM_W'(mat_old) + $signed(pp[MAT_SUM_W-1:0]);
    vec_sum = VEC_SUM_W'(vec_old) + $signed(pp[VEC_SUM_W-1:0]);
    mat_sat = (mat_sum > MAT_SUM_W'(MAT_MAX)) || (mat_sum < MAT_SUM_W'(MAT_MIN));
    vec_sat = (vec_sum > VEC_SUM_W'(VEC_MAX)) || (vec_sum < VEC_SUM_W'(VEC_MIN));
    if (mat_sum > MAT_SUM_W'(MAT_MAX))      mat_new = MAT_MAX;
    else if (mat_sum < MAT_SUM_W'(MAT_MIN)) mat_new = MAT_MIN;
    else                                    mat_new = mat_sum[MAT_W-1:0];
    if (vec_sum > VEC_SUM_W'(VEC_MAX))      vec_new = VEC_MAX;
    else if (vec_sum < VEC_SUM_W'(VEC_MIN)) vec_new = VEC_MIN;
    else                                    vec_new = vec_sum[VEC_W-1:0];
  end

  // Wide accumulate of shifted partial products
  always_comb begin
    pp_sh    = NUM_W'(pp) <<< {pp_dig, 4'b0000};
    acc_base = pp_first ? '0 : acc;
    acc_sum  = pp_sub ? (acc_base - pp_sh) : (acc_base + pp_sh);
  end

  assign group_full = (planes >= CNT_W'(GROUP_MAX));

  // Group sums, counter and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mxx <= '0; mxy <= '0; mxz <= '0; myy <= '0; myz <= '0; mzz <= '0;
      vx <= '0; vy <= '0; vz <= '0;
      planes <= '0;
      ovf    <= 1'b0;
      cclip  <= 1'b0;
      sing   <= 1'b0;
    end else if (cmd.emit) begin
      mxx <= '0; mxy <= '0; mxz <= '0; myy <= '0; myz <= '0; mzz <= '0;
      vx <= '0; vy <= '0; vz <= '0;
      planes <= '0;
      ovf    <= 1'b0;
      cclip  <= 1'b0;
      sing   <= 1'b0;
    end else begin
      if (cmd.load && !group_full) begin
        planes <= planes + CNT_W'(1);
      end
      // dropped plane or saturated sum
      if ((cmd.load && group_full) ||
          (pp_valid && ((pp_is_mat && mat_sat) || (pp_is_vec && vec_sat)))) begin
        ovf <= 1'b1;
      end
      if (pp_valid) begin
        case (pp_dest)
          DST_M0:  mxx <= mat_new;
          DST_M1:  mxy <= mat_new;
          DST_M2:  mxz <= mat_new;
          DST_M3:  myy <= mat_new;
          DST_M4:  myz <= mat_new;
          DST_M5:  mzz <= mat_new;
          DST_V0:  vx  <= vec_new;
          DST_V1:  vy  <= vec_new;
          DST_V2:  vz  <= vec_new;
          default: ;
        endcase
      end
      if (cmd.set_sing) sing <= 1'b1;
      if (div_done && div_clip) cclip <= 1'b1;
    end
  end

  // Plane latch, solver results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u0   <= plane.normal_x;
      u1   <= plane.normal_y;
      u2   <= plane.normal_z;
      h    <= plane.offset;
      last <= plane.last_plane;
    end
    if (pp_valid && !pp_is_mat && !pp_is_vec) begin
      acc <= acc_sum;
      case (pp_dest)
        DST_C0:  c00 <= acc_sum[COF_W-1:0];
        DST_C1:  c01 <= acc_sum[COF_W-1:0];
        DST_C2:  c02 <= acc_sum[COF_W-1:0];
        DST_C3:  c11 <= acc_sum[COF_W-1:0];
        DST_C4:  c12 <= acc_sum[COF_W-1:0];
        DST_C5:  c22 <= acc_sum[COF_W-1:0];
        DST_DET: det <= acc_sum[DET_W-1:0];
        DST_NUM: num <= acc_sum;
        default: ;
      endcase
    end
    if (div_done) begin
      case (cmd.coord)
        2'd0:    p0 <= div_res;
        2'd1:    p1 <= div_res;
        default: p2 <= div_res;
      endcase
    end
  end

  pglsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (num),
    .den      (det),
    .done     (div_done),
    .res      (div_res),
    .res_clip (div_clip)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (cmd.emit) begin
      point_valid <= 1'b1;
    end else if (point_ready) begin
      point_valid <= 1'b0;
    end
    if (cmd.emit) begin
      point.point_x  <= sing ? '0 : p0;
      point.point_y  <= sing ? '0 : p1;
      point.point_z  <= sing ? '0 : p2;
      point.singular <= sing;
      point.clipped  <= ovf | cclip;
    end
  end

  always_comb begin
    stat.group_full = group_full;
    stat.last       = last;
    stat.in_last    = plane.last_plane;
    stat.det_zero   = (det == '0);
    stat.div_done   = div_done;
    stat.out_free   = !point_valid || point_ready;
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!point_valid || point_ready))
    else $error("result written over an item not yet taken");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sing |=> (point.point_x == '0) && (point.point_y == '0)
                         && (point.point_z == '0) && point.singular)
    else $error("singular result carries a nonzero point");
  a_planes_max: assert property (@(posedge clk) disable iff (rst)
    planes <= CNT_W'(GROUP_MAX))
    else $error("plane count above group limit");
`endif

endmodule
`default_nettype wire

FILE: src/pglsp_ctrl.sv
`default_nettype none
module pglsp_ctrl import pglsp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  plane_valid,
  output logic       plane_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t            state, state_next;
  logic [TERM_W-1:0] term, term_next;
  logic [1:0]        digit, digit_next;
  logic [1:0]        coord, coord_next;
  term_t             t;
  logic              dig_last;

  assign t        = term_rom(term);
  assign dig_last = (digit == t.ndig);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term  <= '0;
      digit <= '0;
      coord <= '0;
    end else begin
      state <= state_next;
      term  <= term_next;
      digit <= digit_next;
      coord <= coord_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    term_next  = term;
    digit_next = digit;
    coord_next = coord;
    case (state)
      S_IDLE: begin
        if (plane_valid) begin
          digit_next = '0;
          coord_next = '0;
          if (stat.group_full) begin
            term_next  = TERM_SOLVE0;
            state_next = stat.in_last ? S_SOLVE : S_IDLE;
          end else begin
            term_next  = '0;
            state_next = S_ACC;
          end
        end
      end
      S_ACC: begin
        term_next = term + TERM_W'(1);
        if (term == TERM_ACC_LAST) begin
          state_next = stat.last ? S_DRAIN : S_IDLE;
        end
      end
      S_SOLVE: begin
        if (dig_last) begin
          digit_next = '0;
          term_next  = term + TERM_W'(1);
          if (t.dest == DST_DET || t.dest == DST_NUM) state_next = S_DRAIN;
        end else begin
          digit_next = digit + 2'd1;
        end
      end
      S_DRAIN: state_next = S_NEXT;
      S_NEXT: begin
        if (term == TERM_SOLVE0) begin
          state_next = S_SOLVE;
        end else if (term == TERM_NUM0) begin
          state_next = stat.det_zero ? S_EMIT : S_SOLVE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          coord_next = coord + 2'd1;
          state_next = (coord == LAST_COORD) ? S_EMIT : S_SOLVE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    plane_ready   = (state == S_IDLE);
    cmd           = '0;
    cmd.a_sel     = t.a_sel;
    cmd.b_sel     = t.b_sel;
    cmd.digit     = digit;
    cmd.top       = dig_last;
    cmd.sub       = t.sub;
    cmd.dest      = DST_NONE;
    cmd.coord     = coord;
    case (state)
      S_IDLE: cmd.load = plane_valid;
      S_ACC, S_SOLVE: begin
        cmd.issue = 1'b1;
        cmd.first = t.first && (digit == 2'd0);
        cmd.dest  = dig_last ? t.dest : DST_NONE;
      end
      S_NEXT: begin
        cmd.set_sing  = (term == TERM_NUM0) && stat.det_zero;
        cmd.div_start = (term != TERM_SOLVE0) && (term != TERM_NUM0);
      end
      S_EMIT: cmd.emit = stat.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> state == S_DIV)
    else $error("divider started outside the divide step");
`endif

endmodule
`default_nettype wire

FILE: src/plane_group_least_squares_point_core.sv
`default_nettype none
// Least-squares point of a group of support planes. Each plane item (unit normal in
// Q1.15, offset in Q16.16) adds to a symmetric 3x3 normal matrix and a weighted offset
// vector; the item marked last_plane closes the group, the 3x3 system is solved by
// adjugate and determinant, and one point item in Q16.16 (rounded, saturated) comes out,
// after which the sums clear. Planes beyond GROUP_MAX in a group are dropped and flag
// clipped; a zero determinant gives singular with a zero point. Timing: every product
// goes through one shared 81x17-bit multiplier, one 16-bit digit per cycle. An ordinary
// plane is accepted and then takes nine products; a plane beyond the group limit is
// only accepted. A last plane adds the solve: the S_DRAIN and S_NEXT settle states, the
// adjugate and determinant products, the settle states again, then per coordinate the
// numerator products, the settle states and the 34-step restoring divider. When the
// matrix is singular the numerator products and divisions are skipped. A finished
// point waits in an output register while the next group's planes are taken; only
// the writing of the next point waits for it to be taken.
module plane_group_least_squares_point_core import pglsp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   plane_valid,
  output logic        plane_ready,
  input  wire plane_t plane,
  output logic        point_valid,
  input  wire logic   point_ready,
  output point_t      point
);

  cmd_t  cmd;
  stat_t stat;

  pglsp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .plane_valid (plane_valid),
    .plane_ready (plane_ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  pglsp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .plane       (plane),
    .cmd         (cmd),
    .stat        (stat),
    .point       (point),
    .point_valid (point_valid),
    .point_ready (point_ready)
  );

endmodule
`default_nettype wire

FILE: dv/tb_plane_group_least_squares_point_core.sv
`timescale 1ns / 100ps
module tb_plane_group_least_squares_point_core;
  import pglsp_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic [255:0] uwide_t;

  logic   clk;
  logic   rst;
  logic   plane_valid;
  logic   plane_ready;
  plane_t plane;
  logic   point_valid;
  logic   point_ready;
  point_t point;

  plane_group_least_squares_point_core uut (
    .clk(clk), .rst(rst),
    .plane_valid(plane_valid), .plane_ready(plane_ready), .plane(plane),
    .point_valid(point_valid), .point_ready(point_ready), .point(point)
  );

  // Planes waiting to be sent; a set flag holds the plane until all points are out
  plane_t pending_planes[$];
  bit     drain_first[$];
  point_t expected_points[$];

  // Predictor state
  logic signed [MAT_W-1:0] mat_sum[6];
  logic signed [VEC_W-1:0] vec_sum[3];
  int  planes_in_group;
  bit  group_overflow;

  int  err_count;
  int  planes_accepted;
  int  cycle_count;
  int  send_idle_pct;
  int  recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void clear_group();
    for (int i = 0; i < 6; i++) mat_sum[i] = '0;
    for (int i = 0; i < 3; i++) vec_sum[i] = '0;
    planes_in_group = 0;
    group_overflow  = 1'b0;
  endfunction

  function automatic logic signed [MAT_W-1:0] add_mat(logic signed [MAT_W-1:0] a,
                                                     longint p);
    longint s;
    s = longint'(a) + p;
    if (s > longint'(MAT_MAX)) begin
      group_overflow = 1'b1;
      return MAT_MAX;
    end
    if (s < longint'(MAT_MIN)) begin
      group_overflow = 1'b1;
      return MAT_MIN;
    end
    return s[MAT_W-1:0];
  endfunction

  function automatic logic signed [VEC_W-1:0] add_vec(logic signed [VEC_W-1:0] a,
                                                     longint p);
    longint s;
    s = longint'(a) + p;
    if (s > longint'(VEC_MAX)) begin
      group_overflow = 1'b1;
      return VEC_MAX;
    end
    if (s < longint'(VEC_MIN)) begin
      group_overflow = 1'b1;
      return VEC_MIN;
    end
    return s[VEC_W-1:0];
  endfunction

  // round(num * 2^15 / det) with ties away from zero, saturated
  function automatic logic signed [PT_W-1:0] divide_coord(wide_t num, wide_t det,
                                                         inout bit clip);
    bit     neg;
    uwide_t an, ad, q;
    neg = (num < 0) != (det < 0);
    an  = (num < 0) ? uwide_t'(-num) : uwide_t'(num);
    ad  = (det < 0) ? uwide_t'(-det) : uwide_t'(det);
    q   = ((an << 16) + ad) / (ad << 1);
    if (neg) begin
      if (q[255:32] != 0 || q[31:0] > 32'h8000_0000) begin
        clip = 1'b1;
        return PT_MIN;
      end
      return -q[31:0];
    end
    if (q[255:32] != 0 || q[31:0] > 32'h7FFF_FFFF) begin
      clip = 1'b1;
      return PT_MAX;
    end
    return q[31:0];
  endfunction

  // Accumulate one plane; returns 1 with the solved point on a last plane
  function automatic bit solve_plane(plane_t p, output point_t res);
    longint u[3];
    longint h;
    int     k;
    wide_t  a00, a01, a02, a11, a12, a22, b0, b1, b2;
    wide_t  c00, c01, c02, c11, c12, c22, det;
    bit     clip;
    u[0] = p.normal_x;
    u[1] = p.normal_y;
    u[2] = p.normal_z;
    h    = p.offset;
    res  = '0;
    if (planes_in_group >= GROUP_MAX) begin
      group_overflow = 1'b1;
    end else begin
      k = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = i; j < 3; j++) begin
          mat_sum[k] = add_mat(mat_sum[k], u[i] * u[j]);
          k++;
        end
        vec_sum[i] = add_vec(vec_sum[i], u[i] * h);
      end
      planes_in_group++;
    end
    if (!p.last_plane) return 1'b0;

    a00 = mat_sum[0]; a01 = mat_sum[1]; a02 = mat_sum[2];
    a11 = mat_sum[3]; a12 = mat_sum[4]; a22 = mat_sum[5];
    b0 = vec_sum[0]; b1 = vec_sum[1]; b2 = vec_sum[2];
    c00 = a11 * a22 - a12 * a12;
    c01 = a02 * a12 - a01 * a22;
    c02 = a01 * a12 - a02 * a11;
    c11 = a00 * a22 - a02 * a02;
    c12 = a01 * a02 - a00 * a12;
    c22 = a00 * a11 - a01 * a01;
    det = a00 * c00 + a01 * c01 + a02 * c02;
    clip = group_overflow;
    if (det == 0) begin
      res.singular = 1'b1;
    end else begin
      res.point_x = divide_coord(c00 * b0 + c01 * b1 + c02 * b2, det, clip);
      res.point_y = divide_coord(c01 * b0 + c11 * b1 + c12 * b2, det, clip);
      res.point_z = divide_coord(c02 * b0 + c12 * b1 + c22 * b2, det, clip);
    end
    res.clipped = clip;
    clear_group();
    return 1'b1;
  endfunction

  function automatic plane_t make_plane(int nx, int ny, int nz, int ofs, bit lst);
    plane_t p;
    p.normal_x   = nx[15:0];
    p.normal_y   = ny[15:0];
    p.normal_z   = nz[15:0];
    p.offset     = ofs;
    p.last_plane = lst;
    return p;
  endfunction

  task automatic queue_plane(plane_t p, bit hold);
    pending_planes.insert(pending_planes.size(), p);
    drain_first.insert(drain_first.size(), hold);
  endtask

  // Random group of planes with random content
  task automatic queue_group(int len, bit hold);
    int  nx, ny, nz, sel;
    plane_t p;
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        nx = $urandom; ny = $urandom; nz = $urandom;
      end else if (sel < 8) begin
        // near-axis normals keep the system well conditioned
        nx = $urandom_range(40000) - 20000;
        ny = $urandom_range(40000) - 20000;
        nz = (i % 3 == 0) ? 32767 : -32768;
      end else begin
        nx = $urandom_range(4) - 2; ny = $urandom_range(4) - 2; nz = $urandom_range(4) - 2;
      end
      p = make_plane(nx, ny, nz, $urandom, i == len - 1);
      if ($urandom_range(3) == 0) p.offset = $urandom_range(2000) - 1000;
      queue_plane(p, hold && i == 0);
    end
  endtask

  // Sender; a held plane also waits for the point of a last plane taken this edge
  always @(posedge clk) begin
    if (rst) begin
      plane_valid <= 1'b0;
    end else if (!plane_valid || plane_ready) begin
      if (pending_planes.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(drain_first[0] && (expected_points.size() > 0 ||
                               (plane_valid && plane_ready && plane.last_plane)))) begin
        plane_valid <= 1'b1;
        plane       <= pending_planes.pop_front();
        void'(drain_first.pop_front());
      end else begin
        plane_valid <= 1'b0;
      end
    end
  end

  // Prediction, receiver and result check
  always @(posedge clk) begin
    point_t res;
    point_t want;
    if (rst) begin
      point_ready <= 1'b0;
    end else begin
      point_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (plane_valid && plane_ready) begin
        planes_accepted++;
        if (solve_plane(plane, res)) expected_points.insert(expected_points.size(), res);
      end
      if (point_valid && point_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected point items", 1, 0);
        end else begin
          want = expected_points.pop_front();
          if (point.point_x !== want.point_x)
            report_mismatch("point_x", point.point_x, want.point_x);
          if (point.point_y !== want.point_y)
            report_mismatch("point_y", point.point_y, want.point_y);
          if (point.point_z !== want.point_z)
            report_mismatch("point_z", point.point_z, want.point_z);
          if (point.singular !== want.singular)
            report_mismatch("singular", point.singular, want.singular);
          if (point.clipped !== want.clipped)
            report_mismatch("clipped", point.clipped, want.clipped);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int total;
    err_count = 0;
    planes_accepted = 0;
    cycle_count = 0;
    send_idle_pct = 27;
    recv_idle_pct = 63;
    clear_group();
    rst = 1'b1;
    plane_valid = 1'b0;
    point_ready = 1'b0;
    plane = '0;

    // Directed: lone last plane, axis planes, extremes, tiny normals, zero normals
    queue_plane(make_plane(0, 0, 0, 0, 1), 0);
    queue_plane(make_plane(32767, 0, 0, 32'h0001_0000, 0), 0);
    queue_plane(make_plane(0, 32767, 0, -32'sh0002_8000, 0), 0);
    queue_plane(make_plane(0, 0, 32767, 32'h7FFF_FFFF, 1), 0);
    queue_plane(make_plane(-32768, -32768, -32768, 32'h8000_0000, 0), 0);
    queue_plane(make_plane(-32768, 32767, 0, 32'h7FFF_FFFF, 0), 0);
    queue_plane(make_plane(0, -32768, 32767, 32'h8000_0000, 1), 0);
    // tiny normals with large offsets push the point out of range
    queue_plane(make_plane(1, 0, 0, 32'h7FFF_FFFF, 0), 0);
    queue_plane(make_plane(0, 1, 0, 32'h8000_0000, 0), 0);
    queue_plane(make_plane(0, 0, -1, 32'h4000_0000, 1), 0);
    // parallel planes give a singular matrix
    queue_plane(make_plane(23170, 23170, 0, 32'h0003_0000, 0), 0);
    queue_plane(make_plane(23170, 23170, 0, 32'h0001_0000, 1), 0);
    // all-ones and alternating bit patterns, exact results
    queue_plane(make_plane(-1, -1, -1, -1, 0), 1);
    queue_plane(make_plane(16'h5555, 16'hAAAA, 16'h5555, 32'h5555_5555, 0), 0);
    queue_plane(make_plane(16'hAAAA, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, 1), 0);
    queue_plane(make_plane(2, 0, 0, 1, 0), 0);
    queue_plane(make_plane(0, 2, 0, 3, 0), 0);
    queue_plane(make_plane(0, 0, 2, -1, 1), 0);
    queue_plane(make_plane(0, 0, 0, 12345, 0), 0);
    queue_plane(make_plane(0, 0, 0, 0, 1), 0);

    // Random groups; a few run past the group limit
    total = pending_planes.size();
    while (total < 320) begin
      int len;
      if ($urandom_range(29) == 0) len = GROUP_MAX + $urandom_range(6);
      else if ($urandom_range(5) == 0) len = $urandom_range(2, 1);
      else len = $urandom_range(8, 3);
      queue_group(len, $urandom_range(15) == 0);
      total += len;
    end
    queue_group(GROUP_MAX + 2, 1'b1);
    total += GROUP_MAX + 2;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Idle profiles by progress through the stimulus
    wait (planes_accepted >= total / 3);
    send_idle_pct = 63;
    recv_idle_pct = 27;
    wait (planes_accepted >= (2 * total) / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    wait (pending_planes.size() == 0 && planes_accepted == total);
    wait (expected_points.size() == 0);
    repeat (300) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/pglsp_pkg.sv
src/pglsp_div.sv
src/pglsp_dp.sv
src/pglsp_ctrl.sv
src/plane_group_least_squares_point_core.sv
dv/tb_plane_group_least_squares_point_core.sv
